// ----- rtl/swcb_pkg.sv -----
// Shared widths, register indexes and item types of the segment wall collision core.
// Used by the core, the port checker and the testbench.
package swcb_pkg;

    localparam int unsigned COORD_W    = 17;
    localparam int unsigned RAD_W      = 12;
    localparam int unsigned REST_W     = 10;
    localparam int unsigned KICK_W     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam int unsigned DIFF_W = COORD_W + 1;
    localparam int unsigned PROD_W = 2 * DIFF_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned L2_W   = PROD_W;
    localparam int unsigned R2_W   = 2 * RAD_W;
    localparam int unsigned PN_W   = SUM_W + DIFF_W;
    localparam int unsigned EPN_W  = PN_W + REST_W + 1;
    localparam int unsigned NUM_W  = 68;
    localparam int unsigned DEN_W  = L2_W + 8;
    localparam int unsigned QUOT_W = 20;
    localparam int unsigned ACP_W  = 31;

    localparam logic [CFG_IDX_W-1:0] REG_WALL_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_COUNT   = 3'd5;

    localparam int FRAC_BITS_DEF = 6;
    localparam int KICK_UNIT     = 90;
    localparam int KICK_BASE_W   = 11;
    localparam int REST_RESET    = 256;
    localparam int VEL_MAX       = 65535;
    localparam int VEL_MIN       = -65536;

    typedef struct packed {
        logic                       hit;
        logic                       neg_x;
        logic                       neg_y;
        logic [KICK_W-1:0]          kick_count;
        logic signed [COORD_W-1:0]  vel_x;
        logic signed [COORD_W-1:0]  vel_y;
    } swcb_side_t;

endpackage

// ----- rtl/swcb_divider.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
// Stand-alone; widths come from its parameters.
module swcb_divider #(
    parameter int unsigned QW    = 20,
    parameter int unsigned REMW  = 68,
    parameter int unsigned DW    = 44,
    parameter int unsigned SIDEW = 41
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REMW-1:0]  in_mag_x,
    input  logic [REMW-1:0]  in_mag_y,
    input  logic [DW-1:0]    in_den,
    input  logic [SIDEW-1:0] in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QW-1:0]    out_q_x,
    output logic [QW-1:0]    out_q_y,
    output logic [SIDEW-1:0] out_side
);

    logic [QW-1:0]    valid_reg;
    logic [QW:0]      adv;
    logic [REMW-1:0]  remx_reg [QW];
    logic [REMW-1:0]  remy_reg [QW];
    logic [QW-1:0]    qx_reg   [QW];
    logic [QW-1:0]    qy_reg   [QW];
    logic [DW-1:0]    den_reg  [QW];
    logic [SIDEW-1:0] side_reg [QW];

    logic [QW-1:0]    valid_next;
    logic [REMW-1:0]  remx_next [QW];
    logic [REMW-1:0]  remy_next [QW];
    logic [QW-1:0]    qx_next   [QW];
    logic [QW-1:0]    qy_next   [QW];
    logic [DW-1:0]    den_next  [QW];
    logic [SIDEW-1:0] side_next [QW];

    assign adv[QW] = out_ready;

    for (genvar s = 0; s < QW; s++) begin : g_adv
        assign adv[s] = !valid_reg[s] || adv[s+1];
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[QW-1];
    assign out_q_x   = qx_reg[QW-1];
    assign out_q_y   = qy_reg[QW-1];
    assign out_side  = side_reg[QW-1];

    always_comb begin
        logic [REMW-1:0] rx, ry, dsh;
        logic [QW-1:0]   qx, qy;
        logic [DW-1:0]   dn;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                valid_next[s] = in_valid;
                rx            = in_mag_x;
                ry            = in_mag_y;
                qx            = '0;
                qy            = '0;
                dn            = in_den;
                side_next[s]  = in_side;
            end else begin
                valid_next[s] = valid_reg[s-1];
                rx            = remx_reg[s-1];
                ry            = remy_reg[s-1];
                qx            = qx_reg[s-1];
                qy            = qy_reg[s-1];
                dn            = den_reg[s-1];
                side_next[s]  = side_reg[s-1];
            end
            dsh         = REMW'(dn) << (QW - 1 - s);
            den_next[s] = dn;
            if (rx >= dsh) begin
                remx_next[s] = rx - dsh;
                qx_next[s]   = {qx[QW-2:0], 1'b1};
            end else begin
                remx_next[s] = rx;
                qx_next[s]   = {qx[QW-2:0], 1'b0};
            end
            if (ry >= dsh) begin
                remy_next[s] = ry - dsh;
                qy_next[s]   = {qy[QW-2:0], 1'b1};
            end else begin
                remy_next[s] = ry;
                qy_next[s]   = {qy[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int s = 0; s < QW; s++) begin
                if (adv[s]) begin
                    valid_reg[s] <= valid_next[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < QW; s++) begin
            if (adv[s]) begin
                remx_reg[s] <= remx_next[s];
                remy_reg[s] <= remy_next[s];
                qx_reg[s]   <= qx_next[s];
                qy_reg[s]   <= qy_next[s];
                den_reg[s]  <= den_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

endmodule

// ----- rtl/segment_wall_collision_bounce_core.sv -----
// Ball against a straight wall segment: contact test and velocity reflection.
// Depends on swcb_pkg and swcb_divider.
//
// Usage: the wall, restitution and kick count are written through the cfg_wr_*
// port while no item is in flight. Each item on the s_ channel (ball centre,
// radius and velocity) yields exactly one item on the m_ channel: a hit flag
// and the new velocity, which equals the input velocity when there is no hit.
// Both channels use valid/ready; an item moves when both are high.
// From acceptance to m_valid an item passes seven stages of products,
// sums and the contact test, twenty stages of the two-lane divider that rounds
// the reflected components (one quotient bit per stage), and the output
// register. One item is accepted every cycle while s_ready is high.
// When the receiver holds m_ready low, the result waits in the output register
// and earlier stages keep filling until every stage holds an item; only then
// does s_ready fall. Nothing is lost or repeated across a stall.
// Reset clears all valid bits and loads the registers with a zero-length wall,
// restitution of one and no kick.
module segment_wall_collision_bounce_core #(
    parameter int FRAC_BITS = swcb_pkg::FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [swcb_pkg::CFG_IDX_W-1:0]            cfg_wr_index,
    input  logic [swcb_pkg::CFG_DATA_W-1:0]           cfg_wr_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [swcb_pkg::COORD_W-1:0]       s_ball_x,
    input  logic signed [swcb_pkg::COORD_W-1:0]       s_ball_y,
    input  logic [swcb_pkg::RAD_W-1:0]                s_ball_radius,
    input  logic signed [swcb_pkg::COORD_W-1:0]       s_vel_x,
    input  logic signed [swcb_pkg::COORD_W-1:0]       s_vel_y,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic                                      m_hit,
    output logic signed [swcb_pkg::COORD_W-1:0]       m_new_vel_x,
    output logic signed [swcb_pkg::COORD_W-1:0]       m_new_vel_y
);
    import swcb_pkg::*;

    localparam int unsigned KW = KICK_BASE_W + FRAC_BITS;
    localparam int unsigned SW = ((KW > QUOT_W) ? KW : QUOT_W) + 2;
    localparam logic signed [SW-1:0] SAT_MAX = SW'(VEL_MAX);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(VEL_MIN);

    function automatic logic signed [COORD_W-1:0] sat_vel(input logic signed [SW-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = COORD_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = COORD_W'(SAT_MIN);
        end else begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

    // Configuration registers
    logic signed [COORD_W-1:0] wall_start_x_reg, wall_start_y_reg;
    logic signed [COORD_W-1:0] wall_end_x_reg, wall_end_y_reg;
    logic [REST_W-1:0]         restitution_reg;
    logic [KICK_W-1:0]         kick_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_start_x_reg <= '0;
            wall_start_y_reg <= '0;
            wall_end_x_reg   <= '0;
            wall_end_y_reg   <= '0;
            restitution_reg  <= REST_W'(REST_RESET);
            kick_count_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_WALL_START_X: wall_start_x_reg <= cfg_wr_data;
                REG_WALL_START_Y: wall_start_y_reg <= cfg_wr_data;
                REG_WALL_END_X:   wall_end_x_reg   <= cfg_wr_data;
                REG_WALL_END_Y:   wall_end_y_reg   <= cfg_wr_data;
                REG_RESTITUTION:  restitution_reg  <= cfg_wr_data[REST_W-1:0];
                REG_KICK_COUNT:   kick_count_reg   <= cfg_wr_data[KICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and advance chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en_out;
    logic div_in_ready, div_out_valid;

    assign en_out  = !m_valid_reg || m_ready;
    assign en7     = !v7_reg || div_in_ready;
    assign en6     = !v6_reg || en7;
    assign en5     = !v5_reg || en6;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg      <= s_valid;
            if (en2)    v2_reg      <= v1_reg;
            if (en3)    v3_reg      <= v2_reg;
            if (en4)    v4_reg      <= v3_reg;
            if (en5)    v5_reg      <= v4_reg;
            if (en6)    v6_reg      <= v5_reg;
            if (en7)    v7_reg      <= v6_reg;
            if (en_out) m_valid_reg <= div_out_valid;
        end
    end

    // Stage 1: differences
    logic signed [DIFF_W-1:0]  dx1_reg, dy1_reg, ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [COORD_W-1:0] vx1_reg, vy1_reg;
    logic [RAD_W-1:0]          r1_reg;
    logic [REST_W-1:0]         e1_reg;
    logic [KICK_W-1:0]         k1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            dx1_reg <= {wall_end_x_reg[COORD_W-1], wall_end_x_reg}
                     - {wall_start_x_reg[COORD_W-1], wall_start_x_reg};
            dy1_reg <= {wall_end_y_reg[COORD_W-1], wall_end_y_reg}
                     - {wall_start_y_reg[COORD_W-1], wall_start_y_reg};
            ax1_reg <= {s_ball_x[COORD_W-1], s_ball_x}
                     - {wall_start_x_reg[COORD_W-1], wall_start_x_reg};
            ay1_reg <= {s_ball_y[COORD_W-1], s_ball_y}
                     - {wall_start_y_reg[COORD_W-1], wall_start_y_reg};
            bx1_reg <= {s_ball_x[COORD_W-1], s_ball_x}
                     - {wall_end_x_reg[COORD_W-1], wall_end_x_reg};
            by1_reg <= {s_ball_y[COORD_W-1], s_ball_y}
                     - {wall_end_y_reg[COORD_W-1], wall_end_y_reg};
            vx1_reg <= s_vel_x;
            vy1_reg <= s_vel_y;
            r1_reg  <= s_ball_radius;
            e1_reg  <= restitution_reg;
            k1_reg  <= kick_count_reg;
        end
    end

    // Stage 2: products
    logic signed [PROD_W-1:0] dxx2_reg, dyy2_reg, axx2_reg, ayy2_reg, bxx2_reg, byy2_reg;
    logic signed [PROD_W-1:0] axdx2_reg, aydy2_reg, bxdx2_reg, bydy2_reg, dyax2_reg, dxay2_reg;
    logic signed [PROD_W-1:0] vxdx2_reg, vydy2_reg, vydx2_reg, vxdy2_reg;
    logic [R2_W-1:0]          r2_2_reg;
    logic signed [DIFF_W-1:0] dx2_reg, dy2_reg;
    logic signed [COORD_W-1:0] vx2_reg, vy2_reg;
    logic [REST_W-1:0]        e2_reg;
    logic [KICK_W-1:0]        k2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            dxx2_reg  <= dx1_reg * dx1_reg;
            dyy2_reg  <= dy1_reg * dy1_reg;
            axx2_reg  <= ax1_reg * ax1_reg;
            ayy2_reg  <= ay1_reg * ay1_reg;
            bxx2_reg  <= bx1_reg * bx1_reg;
            byy2_reg  <= by1_reg * by1_reg;
            axdx2_reg <= ax1_reg * dx1_reg;
            aydy2_reg <= ay1_reg * dy1_reg;
            bxdx2_reg <= bx1_reg * dx1_reg;
            bydy2_reg <= by1_reg * dy1_reg;
            dyax2_reg <= dy1_reg * ax1_reg;
            dxay2_reg <= dx1_reg * ay1_reg;
            vxdx2_reg <= vx1_reg * dx1_reg;
            vydy2_reg <= vy1_reg * dy1_reg;
            vydx2_reg <= vy1_reg * dx1_reg;
            vxdy2_reg <= vx1_reg * dy1_reg;
            r2_2_reg  <= r1_reg * r1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            e2_reg    <= e1_reg;
            k2_reg    <= k1_reg;
        end
    end

    // Stage 3: sums
    logic [L2_W-1:0]          l2_3_reg, d1_3_reg, d2_3_reg;
    logic signed [SUM_W-1:0]  dota3_reg, dotb3_reg, cp3_reg, n3_reg, t3_reg;
    logic [R2_W-1:0]          r2_3_reg;
    logic signed [DIFF_W-1:0] dx3_reg, dy3_reg;
    logic signed [COORD_W-1:0] vx3_reg, vy3_reg;
    logic [REST_W-1:0]        e3_reg;
    logic [KICK_W-1:0]        k3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            l2_3_reg  <= $unsigned(dxx2_reg) + $unsigned(dyy2_reg);
            d1_3_reg  <= $unsigned(axx2_reg) + $unsigned(ayy2_reg);
            d2_3_reg  <= $unsigned(bxx2_reg) + $unsigned(byy2_reg);
            dota3_reg <= axdx2_reg + aydy2_reg;
            dotb3_reg <= bxdx2_reg + bydy2_reg;
            cp3_reg   <= dyax2_reg - dxay2_reg;
            n3_reg    <= vydx2_reg - vxdy2_reg;
            t3_reg    <= vxdx2_reg + vydy2_reg;
            r2_3_reg  <= r2_2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            e3_reg    <= e2_reg;
            k3_reg    <= k2_reg;
        end
    end

    // Stage 4: contact conditions and numerator products
    logic                     ok_next;
    logic [SUM_W-1:0]         acp_next;

    always_comb begin
        logic bad, dot_neg, away, far;
        bad      = (l2_3_reg == '0) || (d1_3_reg == '0) || (d2_3_reg == '0);
        dot_neg  = (d1_3_reg <= d2_3_reg) ? (dota3_reg < 0) : (dotb3_reg > 0);
        away     = (k3_reg == '0)
                && (((n3_reg < 0) && (cp3_reg > 0)) || ((n3_reg > 0) && (cp3_reg < 0)));
        acp_next = (cp3_reg < 0) ? $unsigned(-cp3_reg) : $unsigned(cp3_reg);
        far      = (acp_next[SUM_W-1:ACP_W] != '0);
        ok_next  = !(bad || dot_neg || away || far);
    end

    logic                     ok4_reg;
    logic [ACP_W-1:0]         acp4_reg;
    logic [R2_W+L2_W-1:0]     ld4_reg;
    logic signed [PN_W-1:0]   p1_4_reg, p2_4_reg, p3_4_reg, p4_4_reg;
    logic [L2_W-1:0]          l2_4_reg;
    logic signed [COORD_W-1:0] vx4_reg, vy4_reg;
    logic [REST_W-1:0]        e4_reg;
    logic [KICK_W-1:0]        k4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            ok4_reg  <= ok_next;
            acp4_reg <= acp_next[ACP_W-1:0];
            ld4_reg  <= r2_3_reg * l2_3_reg;
            p1_4_reg <= t3_reg * dx3_reg;
            p2_4_reg <= n3_reg * dy3_reg;
            p3_4_reg <= t3_reg * dy3_reg;
            p4_4_reg <= n3_reg * dx3_reg;
            l2_4_reg <= l2_3_reg;
            vx4_reg  <= vx3_reg;
            vy4_reg  <= vy3_reg;
            e4_reg   <= e3_reg;
            k4_reg   <= k3_reg;
        end
    end

    // Stage 5: squared distance and restitution products
    logic                     ok5_reg;
    logic [2*ACP_W-1:0]       sq5_reg;
    logic [R2_W+L2_W-1:0]     ld5_reg;
    logic signed [EPN_W-1:0]  ep2_5_reg, ep4_5_reg;
    logic signed [PN_W-1:0]   p1_5_reg, p3_5_reg;
    logic [L2_W-1:0]          l2_5_reg;
    logic signed [COORD_W-1:0] vx5_reg, vy5_reg;
    logic [KICK_W-1:0]        k5_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            ok5_reg   <= ok4_reg;
            sq5_reg   <= acp4_reg * acp4_reg;
            ld5_reg   <= ld4_reg;
            ep2_5_reg <= $signed({1'b0, e4_reg}) * p2_4_reg;
            ep4_5_reg <= $signed({1'b0, e4_reg}) * p4_4_reg;
            p1_5_reg  <= p1_4_reg;
            p3_5_reg  <= p3_4_reg;
            l2_5_reg  <= l2_4_reg;
            vx5_reg   <= vx4_reg;
            vy5_reg   <= vy4_reg;
            k5_reg    <= k4_reg;
        end
    end

    // Stage 6: hit decision and numerators
    logic signed [NUM_W-1:0] numx_next, numy_next;

    always_comb begin
        logic signed [NUM_W-1:0] p1_ext, p3_ext, ep2_ext, ep4_ext;
        p1_ext    = NUM_W'(p1_5_reg);
        p3_ext    = NUM_W'(p3_5_reg);
        ep2_ext   = NUM_W'(ep2_5_reg);
        ep4_ext   = NUM_W'(ep4_5_reg);
        numx_next = (p1_ext <<< 8) + ep2_ext;
        numy_next = (p3_ext <<< 8) - ep4_ext;
    end

    logic                     hit6_reg;
    logic signed [NUM_W-1:0]  numx6_reg, numy6_reg;
    logic [L2_W-1:0]          l2_6_reg;
    logic signed [COORD_W-1:0] vx6_reg, vy6_reg;
    logic [KICK_W-1:0]        k6_reg;

    always_ff @(posedge aclk) begin
        if (en6) begin
            hit6_reg  <= ok5_reg && (sq5_reg < (2*ACP_W)'(ld5_reg));
            numx6_reg <= numx_next;
            numy6_reg <= numy_next;
            l2_6_reg  <= l2_5_reg;
            vx6_reg   <= vx5_reg;
            vy6_reg   <= vy5_reg;
            k6_reg    <= k5_reg;
        end
    end

    // Stage 7: magnitudes with half the divisor added for rounding
    logic [NUM_W-1:0] half_den;
    assign half_den = NUM_W'({l2_6_reg, 7'b0});

    logic [NUM_W-1:0]  magx7_reg, magy7_reg;
    logic [DEN_W-1:0]  den7_reg;
    swcb_side_t        side7_reg;

    always_ff @(posedge aclk) begin
        if (en7) begin
            magx7_reg <= ((numx6_reg < 0) ? $unsigned(-numx6_reg) : $unsigned(numx6_reg))
                       + half_den;
            magy7_reg <= ((numy6_reg < 0) ? $unsigned(-numy6_reg) : $unsigned(numy6_reg))
                       + half_den;
            den7_reg  <= {l2_6_reg, 8'b0};
            side7_reg.hit        <= hit6_reg;
            side7_reg.neg_x      <= (numx6_reg < 0);
            side7_reg.neg_y      <= (numy6_reg < 0);
            side7_reg.kick_count <= k6_reg;
            side7_reg.vel_x      <= vx6_reg;
            side7_reg.vel_y      <= vy6_reg;
        end
    end

    // Rounded division by 256 * L2
    logic [QUOT_W-1:0] qx, qy;
    logic [$bits(swcb_side_t)-1:0] div_side_bits;
    swcb_side_t div_side;

    swcb_divider #(
        .QW    (QUOT_W),
        .REMW  (NUM_W),
        .DW    (DEN_W),
        .SIDEW ($bits(swcb_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v7_reg),
        .in_ready  (div_in_ready),
        .in_mag_x  (magx7_reg),
        .in_mag_y  (magy7_reg),
        .in_den    (den7_reg),
        .in_side   (side7_reg),
        .out_valid (div_out_valid),
        .out_ready (en_out),
        .out_q_x   (qx),
        .out_q_y   (qy),
        .out_side  (div_side_bits)
    );

    assign div_side = swcb_side_t'(div_side_bits);

    // Output stage: sign, kick, saturation; the input velocity when there is no hit
    logic signed [COORD_W-1:0] new_vx_next, new_vy_next;

    always_comb begin
        logic signed [QUOT_W:0]     qx_s, qy_s;
        logic [KICK_BASE_W-1:0]     kick_base;
        logic [KW-1:0]              kick;
        logic signed [SW-1:0]       sum_y;
        qx_s      = div_side.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        qy_s      = div_side.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        kick_base = KICK_BASE_W'(div_side.kick_count) * KICK_BASE_W'(KICK_UNIT);
        kick      = {kick_base, {FRAC_BITS{1'b0}}};
        sum_y     = SW'(qy_s) - $signed(SW'(kick));
        if (div_side.hit) begin
            new_vx_next = sat_vel(SW'(qx_s));
            new_vy_next = sat_vel(sum_y);
        end else begin
            new_vx_next = div_side.vel_x;
            new_vy_next = div_side.vel_y;
        end
    end

    logic                      m_hit_reg;
    logic signed [COORD_W-1:0] m_new_vel_x_reg, m_new_vel_y_reg;

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_hit_reg       <= div_side.hit;
            m_new_vel_x_reg <= new_vx_next;
            m_new_vel_y_reg <= new_vy_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_new_vel_x = m_new_vel_x_reg;
    assign m_new_vel_y = m_new_vel_y_reg;

endmodule

// ----- rtl/swcb_checker.sv -----
// Port-level checks of the segment wall collision core, bound to its top level.
// Depends on swcb_pkg.
module swcb_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_hit,
    input logic signed [swcb_pkg::COORD_W-1:0]  m_new_vel_x,
    input logic signed [swcb_pkg::COORD_W-1:0]  m_new_vel_y
);
    import swcb_pkg::*;

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if (s_valid && s_ready) pending_next = pending_next + 8'd1;
        if (m_valid && m_ready) pending_next = pending_next - 8'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A result that is held back keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit)
            && $stable(m_new_vel_x) && $stable(m_new_vel_y))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Every result comes from an accepted item.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 8'd0)
        else $error("result without an item in flight");

    // An empty block always takes a new item.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 8'd0 |-> s_ready)
        else $error("empty block not ready");

endmodule

bind segment_wall_collision_bounce_core swcb_checker u_swcb_checker (.*);

// ----- tb/sv/tb_segment_wall_collision_bounce_core.sv -----
// Self-checking testbench for segment_wall_collision_bounce_core: drives ball items
// against several wall settings and checks each result against an in-bench predictor.
// Depends on swcb_pkg and the core RTL.
module tb_segment_wall_collision_bounce_core;
    timeunit 1ns;
    timeprecision 1ps;
    import swcb_pkg::*;

    typedef struct {
        logic                      hit;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } bounce_t;

    class bounce_scoreboard;
        longint wsx, wsy, wex, wey, rest, kick;
        bounce_t expected_q[$];
        int errors, results, hits;

        function new();
            wsx = 0; wsy = 0; wex = 0; wey = 0; rest = REST_RESET; kick = 0;
            errors = 0; results = 0; hits = 0;
        endfunction

        function longint round_div(longint num, longint den);
            longint mag;
            mag = (num < 0) ? -num : num;
            mag = (mag + den / 2) / den;
            return (num < 0) ? -mag : mag;
        endfunction

        function longint clip(longint v);
            if (v < VEL_MIN) return VEL_MIN;
            if (v > VEL_MAX) return VEL_MAX;
            return v;
        endfunction

        function bit touches(longint x, longint y, longint r, longint vx, longint vy);
            longint dx, dy, l2, ax, ay, bx, by, d1, d2, dot, cp, cv, acp;
            dx = wex - wsx; dy = wey - wsy;
            l2 = dx * dx + dy * dy;
            ax = x - wsx; ay = y - wsy; bx = x - wex; by = y - wey;
            d1 = ax * ax + ay * ay; d2 = bx * bx + by * by;
            if (l2 == 0 || d1 == 0 || d2 == 0) return 0;
            dot = (d1 <= d2) ? ax * dx + ay * dy : -(bx * dx + by * dy);
            if (dot < 0) return 0;
            cp = dy * ax - dx * ay;
            if (kick == 0) begin
                cv = dy * vx - dx * vy;
                if ((cv > 0 && cp > 0) || (cv < 0 && cp < 0)) return 0;
            end
            acp = (cp < 0) ? -cp : cp;
            if (acp >= (64'sd1 <<< 31)) return 0;
            return acp * acp < r * r * l2;
        endfunction

        function void note_ball(longint x, longint y, longint r, longint vx, longint vy);
            bounce_t e;
            longint dx, dy, l2, t, n, den, nx, ny;
            e.hit = touches(x, y, r, vx, vy);
            e.vx = vx[COORD_W-1:0];
            e.vy = vy[COORD_W-1:0];
            if (e.hit) begin
                dx = wex - wsx; dy = wey - wsy;
                l2 = dx * dx + dy * dy;
                t = vx * dx + vy * dy;
                n = vy * dx - vx * dy;
                den = 256 * l2;
                nx = clip(round_div(t * dx * 256 + rest * n * dy, den));
                ny = clip(round_div(t * dy * 256 - rest * n * dx, den)
                          - kick * KICK_UNIT * (64'sd1 <<< FRAC_BITS_DEF));
                e.vx = nx[COORD_W-1:0];
                e.vy = ny[COORD_W-1:0];
            end
            expected_q.push_back(e);
        endfunction

        function void check_result(logic h, logic signed [COORD_W-1:0] vx,
                                   logic signed [COORD_W-1:0] vy);
            bounce_t e;
            results++;
            if (h) hits++;
            if (expected_q.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (h !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, h); errors++;
            end
            if (vx !== e.vx) begin
                $error("new_vel_x: expected %0d, got %0d", e.vx, vx); errors++;
            end
            if (vy !== e.vy) begin
                $error("new_vel_y: expected %0d, got %0d", e.vy, vy); errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic s_valid, s_ready, m_valid, m_ready, m_hit;
    logic signed [COORD_W-1:0] s_ball_x, s_ball_y, s_vel_x, s_vel_y;
    logic signed [COORD_W-1:0] m_new_vel_x, m_new_vel_y;
    logic [RAD_W-1:0] s_ball_radius;

    bounce_scoreboard sb = new();
    bit idling;
    int hold_cycles;
    int quiet_cycles;
    int items_sent;

    segment_wall_collision_bounce_core dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_ball(s_ball_x, s_ball_y, s_ball_radius, s_vel_x, s_vel_y);
            if (m_valid && m_ready)
                sb.check_result(m_hit, m_new_vel_x, m_new_vel_y);
            quiet_cycles <= (s_valid && s_ready) || (m_valid && m_ready) ? 0
                                                                          : quiet_cycles + 1;
            if (quiet_cycles >= 3000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            gap = idling ? $urandom_range(0, 7) : 0;
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            repeat (gap) @(negedge aclk) m_ready <= 0;
            @(negedge aclk) m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_ball(longint x, longint y, longint r, longint vx, longint vy);
        int gap;
        gap = idling ? $urandom_range(0, 7) : 0;
        repeat (gap) @(negedge aclk) s_valid <= 0;
        @(negedge aclk);
        s_valid <= 1;
        s_ball_x <= x[COORD_W-1:0];
        s_ball_y <= y[COORD_W-1:0];
        s_ball_radius <= r[RAD_W-1:0];
        s_vel_x <= vx[COORD_W-1:0];
        s_vel_y <= vy[COORD_W-1:0];
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic set_wall(longint sx, longint sy, longint ex, longint ey,
                            longint rest, longint kick);
        longint vals[6];
        vals = '{sx, sy, ex, ey, rest, kick};
        @(negedge aclk) s_valid <= 0;
        wait (sb.expected_q.size() == 0);
        repeat (40) @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1;
            cfg_wr_index <= i[CFG_IDX_W-1:0];
            cfg_wr_data <= vals[i][CFG_DATA_W-1:0];
        end
        @(negedge aclk) cfg_wr_en <= 0;
        sb.wsx = sx; sb.wsy = sy; sb.wex = ex; sb.wey = ey;
        sb.rest = rest & 10'h3FF; sb.kick = kick & 4'hF;
    endtask

    function automatic longint rnd_coord();
        return longint'($urandom_range(0, 131071)) - 65536;
    endfunction

    function automatic longint clamp17(longint v);
        return v < VEL_MIN ? VEL_MIN : (v > VEL_MAX ? VEL_MAX : v);
    endfunction

    task automatic near_ball();
        longint k, r, x, y, vx, vy;
        k = $urandom_range(0, 64);
        r = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(1, 600);
        x = clamp17(sb.wsx + (sb.wex - sb.wsx) * k / 64 + $signed($urandom_range(0, 2 * r)) - r);
        y = clamp17(sb.wsy + (sb.wey - sb.wsy) * k / 64 + $signed($urandom_range(0, 2 * r)) - r);
        vx = $urandom_range(0, 1) ? rnd_coord() : longint'($urandom_range(0, 4000)) - 2000;
        vy = $urandom_range(0, 1) ? rnd_coord() : longint'($urandom_range(0, 4000)) - 2000;
        send_ball(x, y, r, vx, vy);
    endtask

    initial begin
        longint walls[8][6];
        aresetn = 0; cfg_wr_en = 0; cfg_wr_index = '0; cfg_wr_data = '0;
        s_valid = 0; s_ball_x = '0; s_ball_y = '0; s_ball_radius = '0;
        s_vel_x = '0; s_vel_y = '0;
        idling = 0; hold_cycles = 0; quiet_cycles = 0; items_sent = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // Reset wall has zero length, so nothing may hit.
        send_ball(0, 0, 4095, 100, -100);
        send_ball(-65536, 65535, 0, 65535, -65536);

        set_wall(-6400, 0, 6400, 0, 256, 0);
        send_ball(-6400, 0, 500, 0, -300);
        send_ball(6400, 0, 500, 0, -300);
        send_ball(0, 100, 200, 50, -300);
        send_ball(0, 100, 200, 50, 300);
        send_ball(0, -100, 200, 50, 300);
        send_ball(7000, 10, 4095, 0, -300);
        send_ball(-7000, 10, 4095, 0, 300);
        send_ball(0, 0, 4095, 65535, -65536);
        send_ball(10, 1, 4095, -65536, 65535);
        send_ball(0, 65535, 4095, 0, -300);
        send_ball(100, 64, 64, 0, -64);
        set_wall(-65536, 0, 65535, 0, 1023, 15);
        send_ball(0, 65535, 4095, 0, 0);
        send_ball(0, -65536, 4095, 0, 0);
        send_ball(0, 100, 4095, 65535, 65535);
        send_ball(0, -100, 4095, -65536, -65536);
        set_wall(-65536, -65536, 65535, 65535, 0, 0);
        send_ball(0, 100, 4095, 0, -65536);
        send_ball(0, -100, 4095, 65535, 0);

        walls = '{'{-3000, -2000, 4000, 2500, 256, 0},
                  '{0, 0, 0, 0, 300, 3},
                  '{-20000, 5000, -20000, -5000, 512, 0},
                  '{-65536, -65536, 65535, 65535, 1023, 15},
                  '{100, 40000, 30000, 40000, 0, 1},
                  '{65535, -65536, -65536, 65535, 128, 7},
                  '{-500, 700, 800, -600, 200, 0},
                  '{1000, 1000, 1040, 1100, 400, 2}};
        for (int p = 0; p < 8; p++) begin
            set_wall(walls[p][0], walls[p][1], walls[p][2], walls[p][3],
                     walls[p][4], walls[p][5]);
            idling = (p % 3) != 0;
            for (int i = 0; i < 100; i++) begin
                if (p == 2 && i == 10) hold_cycles = 150;
                if ($urandom_range(0, 4) == 0)
                    send_ball(rnd_coord(), rnd_coord(), $urandom_range(0, 4095),
                              rnd_coord(), rnd_coord());
                else
                    near_ball();
            end
        end

        @(negedge aclk) s_valid <= 0;
        wait (sb.expected_q.size() == 0);
        repeat (40) @(posedge aclk);
        $display("Sent %0d ball items over 11 wall settings; %0d results, %0d hits.",
                 items_sent, sb.results, sb.hits);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
